// ===== rtl/core/htfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package htfc_pkg;

  localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
  localparam logic [3:0]  TYPE_THREE  = 4'hA;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h8408;
  localparam logic [15:0] CRC_XOROUT  = 16'hFFFF;
  localparam logic [10:0] MIN_LENGTH  = 11'd4;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Depth of the queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_WRONG_TYPE = 3'd1,
    ST_SEGMENTED  = 3'd2,
    ST_INCOMPLETE = 3'd3,
    ST_BAD_DEST   = 3'd4,
    ST_BAD_SRC    = 3'd5,
    ST_CRC        = 3'd6,
    ST_NO_FRAME   = 3'd7
  } status_e;

  typedef enum logic [3:0] {
    PH_HUNT = 4'd0,
    PH_FMT1 = 4'd1,
    PH_FMT2 = 4'd2,
    PH_DEST = 4'd3,
    PH_SRC  = 4'd4,
    PH_CTRL = 4'd5,
    PH_DATA = 4'd6,
    PH_SKIP = 4'd7,
    PH_DROP = 4'd8
  } phase_e;

  // One received item after classification.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       eod;
    logic       is_flag;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic              full;
    logic [QCNT_W-1:0] count;
  } qstat_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    status_e     status;
    logic [13:0] dest_upper;
    logic [13:0] dest_lower;
    logic [13:0] src_upper;
    logic [13:0] src_lower;
    logic [7:0]  control;
    logic [10:0] frame_length;
  } res_t;

  // One byte of reflected CRC-16/X.25.
  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/htfc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module htfc_front (
  input  wire logic            in_valid_i,
  input  wire logic [7:0]      rx_byte_i,
  input  wire logic            end_of_data_i,
  input  wire htfc_pkg::qstat_t q_stat_i,
  output logic                 in_stall_o,
  output logic                 push_o,
  output htfc_pkg::item_t      item_o
);
  import htfc_pkg::*;

  // The front takes an item whenever the queue has room.
  assign in_stall_o      = q_stat_i.full;
  assign push_o          = in_valid_i & ~q_stat_i.full;

  assign item_o.rx_byte  = rx_byte_i;
  assign item_o.eod      = end_of_data_i;
  assign item_o.is_flag  = (rx_byte_i == FLAG_BYTE);

endmodule

`default_nettype wire

// ===== rtl/core/htfc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module htfc_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire htfc_pkg::item_t  item_i,
  input  wire logic             pop_i,
  output htfc_pkg::item_t       item_o,
  output htfc_pkg::qstat_t      stat_o
);
  import htfc_pkg::*;

  item_t             entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  function automatic logic [QPTR_W-1:0] ptr_next(logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QDEPTH - 1)) begin
      return '0;
    end
    return p + QPTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o       = entry_q[rd_ptr_q];
  assign stat_o.valid = (count_q != '0);
  assign stat_o.full  = (count_q == QCNT_W'(QDEPTH));
  assign stat_o.count = count_q;

endmodule

`default_nettype wire

// ===== rtl/core/htfc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module htfc_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire htfc_pkg::item_t  item_i,
  input  wire htfc_pkg::qstat_t q_stat_i,
  output logic                  pop_o,
  input  wire logic             out_stall_i,
  output logic                  out_valid_o,
  output htfc_pkg::res_t        res_o
);
  import htfc_pkg::*;

  typedef struct packed {
    logic [27:0] acc;
    logic [2:0]  cnt;
    logic        done;
    logic        bad;
  } addr_step_t;

  phase_e      phase_q, phase_d;
  logic [10:0] byte_count_q, byte_count_d;
  logic [10:0] len_q, len_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] fcs_q, fcs_d;
  logic [2:0]  dest_n_q, dest_n_d;
  logic [2:0]  src_n_q, src_n_d;
  logic [27:0] dest_acc_q, dest_acc_d;
  logic [27:0] src_acc_q, src_acc_d;
  logic [7:0]  ctrl_q, ctrl_d;
  logic        dest_bad_q, dest_bad_d;
  logic        src_bad_q, src_bad_d;
  logic        out_valid_q;
  res_t        out_q;

  logic        res_valid;
  res_t        res;
  res_t        stat_res;
  logic        dest_ok, src_ok;
  logic [27:0] dest_dec, src_dec;
  addr_step_t  dest_step, src_step;
  logic [10:0] len_new;
  logic [7:0]  b;

  function automatic logic [27:0] addr_decode(logic [27:0] acc, logic [2:0] n, logic ok);
    logic [13:0] up;
    logic [13:0] lo;
    up = '0;
    lo = '0;
    unique case (n)
      3'd1: up = {7'd0, acc[6:0]};
      3'd2: begin
        up = {7'd0, acc[13:7]};
        lo = {7'd0, acc[6:0]};
      end
      3'd4: begin
        up = acc[27:14];
        lo = acc[13:0];
      end
      default: begin
        up = '0;
        lo = '0;
      end
    endcase
    if (!ok) begin
      up = '0;
      lo = '0;
    end
    return {up, lo};
  endfunction

  // An address byte ends the field when its low bit is set; an end on the third
  // byte, or no end within four bytes, makes it bad.
  function automatic addr_step_t addr_shift(logic [27:0] acc, logic [2:0] cnt,
                                            logic [7:0] v);
    addr_step_t s;
    s.acc  = {acc[20:0], v[7:1]};
    s.cnt  = cnt + 3'd1;
    s.done = v[0] && (s.cnt != 3'd3);
    s.bad  = v[0] ? (s.cnt == 3'd3) : (s.cnt >= 3'd4);
    return s;
  endfunction

  assign b         = item_i.rx_byte;
  assign dest_ok   = (phase_q == PH_SRC) || (phase_q == PH_CTRL) || (phase_q == PH_DATA) ||
                     ((phase_q == PH_SKIP) && src_bad_q);
  assign src_ok    = (phase_q == PH_CTRL) || (phase_q == PH_DATA);
  assign dest_dec  = addr_decode(dest_acc_q, dest_n_q, dest_ok);
  assign src_dec   = addr_decode(src_acc_q, src_n_q, src_ok);
  assign dest_step = addr_shift(dest_acc_q, dest_n_q, b);
  assign src_step  = addr_shift(src_acc_q, src_n_q, b);
  assign len_new   = {fcs_q[2:0], b};

  always_comb begin
    stat_res.kind         = KIND_STATUS;
    stat_res.data_byte    = '0;
    stat_res.status       = ST_OK;
    stat_res.dest_upper   = dest_dec[27:14];
    stat_res.dest_lower   = dest_dec[13:0];
    stat_res.src_upper    = src_dec[27:14];
    stat_res.src_lower    = src_dec[13:0];
    stat_res.control      = ctrl_q;
    stat_res.frame_length = len_q;
  end

  always_comb begin
    phase_d      = phase_q;
    byte_count_d = byte_count_q;
    len_d        = len_q;
    crc_d        = crc_q;
    fcs_d        = fcs_q;
    dest_n_d     = dest_n_q;
    src_n_d      = src_n_q;
    dest_acc_d   = dest_acc_q;
    src_acc_d    = src_acc_q;
    ctrl_d       = ctrl_q;
    dest_bad_d   = dest_bad_q;
    src_bad_d    = src_bad_q;
    res_valid    = 1'b0;
    res          = stat_res;

    if (item_i.eod) begin
      if (phase_q == PH_HUNT) begin
        res_valid  = 1'b1;
        res.status = ST_NO_FRAME;
      end else if (phase_q == PH_DROP) begin
        phase_d = PH_HUNT;
      end else begin
        res_valid  = 1'b1;
        res.status = ST_INCOMPLETE;
        phase_d    = PH_HUNT;
      end
    end else begin
      unique case (phase_q) inside
        PH_HUNT: begin
          if (item_i.is_flag) begin
            phase_d      = PH_FMT1;
            byte_count_d = '0;
            len_d        = '0;
            crc_d        = CRC_INIT;
            fcs_d        = '0;
            dest_n_d     = '0;
            src_n_d      = '0;
            dest_acc_d   = '0;
            src_acc_d    = '0;
            ctrl_d       = '0;
            dest_bad_d   = 1'b0;
            src_bad_d    = 1'b0;
          end
        end
        PH_DROP: begin
          phase_d = PH_DROP;
        end
        PH_FMT1: begin
          fcs_d        = {8'h00, b};
          crc_d        = crc_step(crc_q, b);
          byte_count_d = 11'd1;
          phase_d      = PH_FMT2;
        end
        PH_FMT2: begin
          crc_d               = crc_step(crc_q, b);
          len_d               = len_new;
          byte_count_d        = 11'd2;
          res.frame_length    = len_new;
          if (fcs_q[7:4] != TYPE_THREE) begin
            res_valid  = 1'b1;
            res.status = ST_WRONG_TYPE;
            phase_d    = PH_DROP;
          end else if (fcs_q[3]) begin
            res_valid  = 1'b1;
            res.status = ST_SEGMENTED;
            phase_d    = PH_DROP;
          end else if (len_new < MIN_LENGTH) begin
            res_valid  = 1'b1;
            res.status = ST_INCOMPLETE;
            phase_d    = PH_HUNT;
          end else begin
            phase_d = PH_DEST;
          end
        end
        PH_DEST, PH_SRC, PH_CTRL, PH_DATA, PH_SKIP: begin
          byte_count_d = byte_count_q + 11'd1;
          if (byte_count_q < (len_q - 11'd2)) begin
            crc_d = crc_step(crc_q, b);
            if (phase_q == PH_DEST) begin
              dest_acc_d = dest_step.acc;
              dest_n_d   = dest_step.cnt;
              if (dest_step.done) begin
                phase_d = PH_SRC;
              end else if (dest_step.bad) begin
                dest_bad_d = 1'b1;
                phase_d    = PH_SKIP;
              end
            end else if (phase_q == PH_SRC) begin
              src_acc_d = src_step.acc;
              src_n_d   = src_step.cnt;
              if (src_step.done) begin
                phase_d = PH_CTRL;
              end else if (src_step.bad) begin
                src_bad_d = 1'b1;
                phase_d   = PH_SKIP;
              end
            end else if (phase_q == PH_CTRL) begin
              ctrl_d  = b;
              phase_d = PH_DATA;
            end else if (phase_q == PH_DATA) begin
              res_valid     = 1'b1;
              res           = '0;
              res.kind      = KIND_DATA;
              res.data_byte = b;
            end
          end else if (byte_count_q == (len_q - 11'd2)) begin
            fcs_d = {8'h00, b};
          end else if (byte_count_q == (len_q - 11'd1)) begin
            fcs_d = {b, fcs_q[7:0]};
          end else begin
            res_valid = 1'b1;
            phase_d   = PH_HUNT;
            if (!item_i.is_flag) begin
              res.status = ST_INCOMPLETE;
            end else if (dest_bad_q || (phase_q == PH_DEST)) begin
              res.status = ST_BAD_DEST;
            end else if (src_bad_q || (phase_q == PH_SRC)) begin
              res.status = ST_BAD_SRC;
            end else if ((crc_q ^ CRC_XOROUT) != fcs_q) begin
              res.status = ST_CRC;
            end else begin
              res.status = ST_OK;
            end
          end
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  // An item that gives no result may go ahead even while the output waits.
  assign pop_o = q_stat_i.valid && (!res_valid || !out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      byte_count_q <= '0;
      len_q        <= '0;
      crc_q        <= CRC_INIT;
      fcs_q        <= '0;
      dest_n_q     <= '0;
      src_n_q      <= '0;
      dest_acc_q   <= '0;
      src_acc_q    <= '0;
      ctrl_q       <= '0;
      dest_bad_q   <= 1'b0;
      src_bad_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q      <= phase_d;
        byte_count_q <= byte_count_d;
        len_q        <= len_d;
        crc_q        <= crc_d;
        fcs_q        <= fcs_d;
        dest_n_q     <= dest_n_d;
        src_n_q      <= src_n_d;
        dest_acc_q   <= dest_acc_d;
        src_acc_q    <= src_acc_d;
        ctrl_q       <= ctrl_d;
        dest_bad_q   <= dest_bad_d;
        src_bad_q    <= src_bad_d;
      end
      if (pop_o && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/hdlc_type3_frame_checker_top.sv =====
// A result passes from the edge that accepts its item through a queue entry and then the output register.
// Throughput: one received item per cycle unless the queue fills while the output is stalled.
// A two-item queue parts the input side from the parser; the output register parts the far side.
// Reset (rst_ni, asynchronous, active low) empties the queue and output register and
// puts the parser in flag hunting with the CRC at all ones; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module hdlc_type3_frame_checker_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        end_of_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             kind_o,
  output logic [7:0]       data_byte_o,
  output logic [2:0]       status_o,
  output logic [13:0]      dest_upper_o,
  output logic [13:0]      dest_lower_o,
  output logic [13:0]      src_upper_o,
  output logic [13:0]      src_lower_o,
  output logic [7:0]       control_o,
  output logic [10:0]      frame_length_o
);
  import htfc_pkg::*;

  item_t  push_item;
  item_t  head_item;
  qstat_t q_stat;
  logic   q_push;
  logic   q_pop;
  res_t   res;

  // The front classifies each incoming item (flag or not) and writes it into the
  // queue whenever there is room; it stalls the sender only when the queue is full.
  htfc_front u_front (
    .in_valid_i    (in_valid_i),
    .rx_byte_i     (rx_byte_i),
    .end_of_data_i (end_of_data_i),
    .q_stat_i      (q_stat),
    .in_stall_o    (in_stall_o),
    .push_o        (q_push),
    .item_o        (push_item)
  );

  // The queue lets the front keep taking items while the back waits on a
  // stalled output.
  htfc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .pop_i   (q_pop),
    .item_o  (head_item),
    .stat_o  (q_stat)
  );

  // The back holds the frame parser: flag hunt, format field, addresses,
  // control byte, payload pass-through, FCS capture and the final status.
  // An item that gives no result is consumed even while the output is stalled.
  htfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (head_item),
    .q_stat_i    (q_stat),
    .pop_o       (q_pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign kind_o         = res.kind;
  assign data_byte_o    = res.data_byte;
  assign status_o       = res.status;
  assign dest_upper_o   = res.dest_upper;
  assign dest_lower_o   = res.dest_lower;
  assign src_upper_o    = res.src_upper;
  assign src_lower_o    = res.src_lower;
  assign control_o      = res.control;
  assign frame_length_o = res.frame_length;

`ifndef SYNTH
  // The parser never takes an item from an empty queue.
  a_pop_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_stat.valid)
    else $error("pop from empty queue");

  // The queue never holds more items than it has entries.
  a_queue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= QCNT_W'(QDEPTH))
    else $error("queue overfilled");

  // A payload item carries no status, control or length.
  a_payload_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == KIND_DATA)) |->
      ((status_o == ST_OK) && (control_o == 8'd0) && (frame_length_o == 11'd0)))
    else $error("payload item with status fields set");

  // Statuses raised before any address is parsed report no addresses.
  a_early_status_no_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == KIND_STATUS) &&
     ((status_o == ST_WRONG_TYPE) || (status_o == ST_SEGMENTED) ||
      (status_o == ST_NO_FRAME))) |->
      ((dest_upper_o == 14'd0) && (dest_lower_o == 14'd0) &&
       (src_upper_o == 14'd0) && (src_lower_o == 14'd0)))
    else $error("early status carries address");
`endif

endmodule

`default_nettype wire

// ===== test/hdlc_type3_frame_checker_top_test.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the type 3 HDLC frame checker.
//
// Every item that the block accepts is also fed to a behavioural model of the
// frame parser kept in this module. Whatever the model or a typed directed row says
// the item causes is queued, and each result item that leaves the block is compared
// field by field with the oldest queued one. A short directed table comes first,
// followed by randomly built frames, most well formed and the rest broken on purpose.
module hdlc_type3_frame_checker_top_test;
  import htfc_pkg::*;

  // Ways in which a random frame can be spoilt.
  typedef enum int {
    FAULT_NONE,
    FAULT_EOD,
    FAULT_CLOSE,
    FAULT_CRC,
    FAULT_DEST,
    FAULT_SRC,
    FAULT_TYPE,
    FAULT_SEG,
    FAULT_SHORT,
    FAULT_LEN,
    FAULT_BYTE,
    FAULT_NOISE
  } fault_e;

  // Verdict after one address byte has been shifted in.
  typedef enum int {
    ADDR_MORE,
    ADDR_DONE,
    ADDR_BAD
  } addr_e;

  typedef struct packed {
    logic [7:0] b;
    logic       e;
  } link_item_t;

  // One row of the directed table. Where typed is set the expected outcome is
  // written in the row itself; otherwise the parser model decides.
  typedef struct {
    logic [7:0] b;
    logic       e;
    bit         typed;
    bit         yields;
    res_t       want;
  } stim_row_t;

  localparam res_t NO_RESULT  = '0;
  localparam int   RAND_ITEMS = 650;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        end_of_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        kind_o;
  logic [7:0]  data_byte_o;
  logic [2:0]  status_o;
  logic [13:0] dest_upper_o;
  logic [13:0] dest_lower_o;
  logic [13:0] src_upper_o;
  logic [13:0] src_lower_o;
  logic [7:0]  control_o;
  logic [10:0] frame_length_o;

  hdlc_type3_frame_checker_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .end_of_data_i  (end_of_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .data_byte_o    (data_byte_o),
    .status_o       (status_o),
    .dest_upper_o   (dest_upper_o),
    .dest_lower_o   (dest_lower_o),
    .src_upper_o    (src_upper_o),
    .src_lower_o    (src_lower_o),
    .control_o      (control_o),
    .frame_length_o (frame_length_o)
  );

  // Results still owed by the block, oldest first.
  res_t        pending_results[$];
  // Items of the random frame that is about to be sent.
  link_item_t  link_q[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatches = 0;
  bit          tx_calm    = 1'b0;
  bit          rx_calm    = 1'b0;

  // State of the parser model.
  phase_e      rx_phase;
  logic [10:0] pos;
  logic [10:0] len_fld;
  logic [15:0] crc_acc;
  logic [15:0] fcs_word;
  logic [2:0]  dest_n;
  logic [2:0]  src_n;
  logic [27:0] dest_acc;
  logic [27:0] src_acc;
  logic [7:0]  ctrl_byte;
  bit          dest_err;
  bit          src_err;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop, several times the longest run that a correct block can need.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Reflected CRC-16/X.25, one data bit at a time.
  function automatic logic [15:0] crc16_x25(logic [15:0] c, logic [7:0] b);
    bit fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ 16'h8408;
    end
    return c;
  endfunction

  // Most gaps are short, a few are long, and calm stretches have none at all.
  function automatic int unsigned idle_len(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic res_t status_only(status_e st, logic [10:0] flen);
    res_t r;
    r              = '0;
    r.kind         = KIND_STATUS;
    r.status       = st;
    r.frame_length = flen;
    return r;
  endfunction

  // Upper and lower halves of an address, 7 bits per address byte.
  function automatic logic [27:0] split_addr(logic [27:0] acc, logic [2:0] n, bit ok);
    if (!ok) return '0;
    case (n)
      3'd1:    return {7'd0, acc[6:0], 14'd0};
      3'd2:    return {7'd0, acc[13:7], 7'd0, acc[6:0]};
      3'd4:    return acc;
      default: return '0;
    endcase
  endfunction

  // End-of-frame status item as built from what the model has parsed so far.
  // An address only counts once the parser has moved beyond it.
  function automatic res_t frame_status(status_e st);
    res_t r;
    bit   d_ok;
    bit   s_ok;
    d_ok = (rx_phase == PH_SRC) || (rx_phase == PH_CTRL) || (rx_phase == PH_DATA) ||
           (rx_phase == PH_SKIP && src_err);
    s_ok = (rx_phase == PH_CTRL) || (rx_phase == PH_DATA);
    r                            = '0;
    r.kind                       = KIND_STATUS;
    r.status                     = st;
    {r.dest_upper, r.dest_lower} = split_addr(dest_acc, dest_n, d_ok);
    {r.src_upper, r.src_lower}   = split_addr(src_acc, src_n, s_ok);
    r.control                    = ctrl_byte;
    r.frame_length               = len_fld;
    return r;
  endfunction

  task automatic clear_frame();
    rx_phase  = PH_HUNT;
    pos       = '0;
    len_fld   = '0;
    crc_acc   = CRC_INIT;
    fcs_word  = '0;
    dest_n    = '0;
    src_n     = '0;
    dest_acc  = '0;
    src_acc   = '0;
    ctrl_byte = '0;
    dest_err  = 1'b0;
    src_err   = 1'b0;
  endtask

  // An address ends at a byte with bit 0 set; three bytes or no end within four
  // is an error.
  task automatic shift_addr(inout logic [27:0] acc, inout logic [2:0] n,
                            input logic [7:0] b, output addr_e verdict);
    n   = n + 3'd1;
    acc = {acc[20:0], b[7:1]};
    if (b[0]) verdict = (n == 3'd3) ? ADDR_BAD : ADDR_DONE;
    else      verdict = (n >= 3'd4) ? ADDR_BAD : ADDR_MORE;
  endtask

  // Parser model: advances on one accepted item and tells whether it causes a
  // result item, and which.
  task automatic predict_byte(input logic [7:0] b, input logic e,
                              output bit yields, output res_t r);
    logic [10:0] idx;
    addr_e       v;
    yields = 1'b0;
    r      = '0;
    if (e) begin
      // End of data: no frame while hunting, silence while dropping, and an
      // incomplete frame anywhere else.
      if (rx_phase == PH_HUNT) begin
        yields = 1'b1;
        r      = frame_status(ST_NO_FRAME);
      end else if (rx_phase != PH_DROP) begin
        yields = 1'b1;
        r      = frame_status(ST_INCOMPLETE);
      end
      rx_phase = PH_HUNT;
      return;
    end
    case (rx_phase)
      PH_HUNT: begin
        if (b == FLAG_BYTE) begin
          clear_frame();
          rx_phase = PH_FMT1;
        end
      end
      PH_DROP: ;
      PH_FMT1: begin
        fcs_word = {8'h00, b};
        crc_acc  = crc16_x25(crc_acc, b);
        pos      = 11'd1;
        rx_phase = PH_FMT2;
      end
      PH_FMT2: begin
        crc_acc = crc16_x25(crc_acc, b);
        len_fld = {fcs_word[2:0], b};
        pos     = 11'd2;
        if (fcs_word[7:4] != TYPE_THREE) begin
          yields   = 1'b1;
          r        = frame_status(ST_WRONG_TYPE);
          rx_phase = PH_DROP;
        end else if (fcs_word[3]) begin
          yields   = 1'b1;
          r        = frame_status(ST_SEGMENTED);
          rx_phase = PH_DROP;
        end else if (len_fld < MIN_LENGTH) begin
          yields   = 1'b1;
          r        = frame_status(ST_INCOMPLETE);
          rx_phase = PH_HUNT;
        end else begin
          rx_phase = PH_DEST;
        end
      end
      default: begin
        idx = pos;
        pos = idx + 11'd1;
        if (idx < len_fld - 11'd2) begin
          crc_acc = crc16_x25(crc_acc, b);
          case (rx_phase)
            PH_DEST: begin
              shift_addr(dest_acc, dest_n, b, v);
              if (v == ADDR_DONE) begin
                rx_phase = PH_SRC;
              end else if (v == ADDR_BAD) begin
                dest_err = 1'b1;
                rx_phase = PH_SKIP;
              end
            end
            PH_SRC: begin
              shift_addr(src_acc, src_n, b, v);
              if (v == ADDR_DONE) begin
                rx_phase = PH_CTRL;
              end else if (v == ADDR_BAD) begin
                src_err  = 1'b1;
                rx_phase = PH_SKIP;
              end
            end
            PH_CTRL: begin
              ctrl_byte = b;
              rx_phase  = PH_DATA;
            end
            PH_DATA: begin
              yields      = 1'b1;
              r.kind      = KIND_DATA;
              r.data_byte = b;
            end
            default: ;
          endcase
        end else if (idx == len_fld - 11'd2) begin
          fcs_word = {8'h00, b};
        end else if (idx == len_fld - 11'd1) begin
          fcs_word[15:8] = b;
        end else begin
          // Byte after the FCS: closing flag first, then addresses, then FCS.
          yields = 1'b1;
          if (b != FLAG_BYTE)                              r = frame_status(ST_INCOMPLETE);
          else if (dest_err || rx_phase == PH_DEST)        r = frame_status(ST_BAD_DEST);
          else if (src_err || rx_phase == PH_SRC)          r = frame_status(ST_BAD_SRC);
          else if ((crc_acc ^ CRC_XOROUT) != fcs_word)     r = frame_status(ST_CRC);
          else                                             r = frame_status(ST_OK);
          rx_phase = PH_HUNT;
        end
      end
    endcase
  endtask

  // Presents one item and returns at the edge that accepts it. Valid is left
  // high so that a following item without a gap goes out back to back; it is
  // only lowered at the start of a gap or by a pause.
  task automatic send_item(input logic [7:0] b, input logic e);
    int unsigned gap;
    gap = idle_len(tx_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    rx_byte_i     <= b;
    end_of_data_i <= e;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Sender holds off until every owed result has come out.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic emit(logic [7:0] b, logic e);
    link_item_t it;
    it.b = b;
    it.e = e;
    link_q.push_back(it);
  endtask

  // Appends one address of 1, 2 or 4 bytes, or a broken one of three bytes or
  // of four or five bytes without an end.
  task automatic add_addr(ref logic [7:0] q[$], input bit bad);
    int         n;
    int         k;
    bit         open_end;
    logic [7:0] v;
    k        = $urandom_range(0, 2);
    n        = (k == 2) ? 4 : k + 1;
    open_end = 1'b0;
    if (bad) begin
      if ($urandom_range(0, 1) != 0) n = 3;
      else begin
        n        = $urandom_range(4, 5);
        open_end = 1'b1;
      end
    end
    for (int i = 0; i < n; i++) begin
      v = 8'($urandom_range(0, 255));
      // Now and then the address bits sit at their extremes.
      case ($urandom_range(0, 7))
        0:       v[7:1] = 7'h7F;
        1:       v[7:1] = 7'h00;
        default: ;
      endcase
      v[0] = !open_end && (i == n - 1);
      q.push_back(v);
    end
  endtask

  // Builds one random frame into link_q, possibly spoilt in one way, with the
  // odd end-of-data or stray byte between frames.
  task automatic build_frame();
    fault_e      f;
    logic [7:0]  body[$];
    int          np;
    int          k;
    logic [10:0] flen;
    logic [7:0]  f0;
    logic [7:0]  f1;
    logic [15:0] c;
    logic [15:0] fcs;
    logic [7:0]  close_b;
    link_q.delete();
    if ($urandom_range(0, 99) < 55) f = FAULT_NONE;
    else                            f = fault_e'($urandom_range(FAULT_EOD, FAULT_NOISE));
    if (f == FAULT_NOISE) begin
      repeat ($urandom_range(1, 4)) emit(8'($urandom_range(0, 255)), 1'b0);
      if ($urandom_range(0, 1) != 0) emit(8'($urandom_range(0, 255)), 1'b1);
      return;
    end
    add_addr(body, f == FAULT_DEST);
    add_addr(body, f == FAULT_SRC);
    body.push_back(8'($urandom_range(0, 255)));
    // Short payloads keep frames quick; a few longer ones go in too.
    np = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
    repeat (np) body.push_back(8'($urandom_range(0, 255)));
    flen = 11'(body.size() + 4);
    case (f)
      FAULT_SHORT: flen = 11'($urandom_range(0, 3));
      FAULT_LEN: begin
        do flen = 11'($urandom_range(4, body.size() + 7));
        while (flen == body.size() + 4);
      end
      default: ;
    endcase
    f0 = {TYPE_THREE, 1'b0, flen[10:8]};
    f1 = flen[7:0];
    if (f == FAULT_TYPE) begin
      do f0[7:4] = 4'($urandom_range(0, 15));
      while (f0[7:4] == TYPE_THREE);
    end
    if (f == FAULT_SEG) f0[3] = 1'b1;
    c = crc16_x25(CRC_INIT, f0);
    c = crc16_x25(c, f1);
    foreach (body[i]) c = crc16_x25(c, body[i]);
    fcs = c ^ CRC_XOROUT;
    if (f == FAULT_CRC) fcs = fcs ^ 16'($urandom_range(1, 65535));
    close_b = FLAG_BYTE;
    if (f == FAULT_CLOSE) begin
      do close_b = 8'($urandom_range(0, 255));
      while (close_b == FLAG_BYTE);
    end
    emit(FLAG_BYTE, 1'b0);
    emit(f0, 1'b0);
    emit(f1, 1'b0);
    foreach (body[i]) emit(body[i], 1'b0);
    emit(fcs[7:0], 1'b0);
    emit(fcs[15:8], 1'b0);
    emit(close_b, 1'b0);
    case (f)
      FAULT_BYTE: begin
        k = $urandom_range(1, link_q.size() - 1);
        link_q[k].b = 8'($urandom_range(0, 255));
      end
      FAULT_EOD: begin
        k = $urandom_range(1, link_q.size() - 1);
        while (link_q.size() > k) void'(link_q.pop_back());
        emit(8'($urandom_range(0, 255)), 1'b1);
      end
      FAULT_TYPE, FAULT_SEG: begin
        // Usually end the drop at once so that the next frame is heard.
        if ($urandom_range(0, 3) != 0) emit(8'($urandom_range(0, 255)), 1'b1);
      end
      default: ;
    endcase
    if ($urandom_range(0, 6) == 0) emit(8'($urandom_range(0, 255)), 1'b1);
    if ($urandom_range(0, 9) == 0) emit(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic field_check(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Result side: compares every accepted result item with the oldest one owed.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result: expected none, actual kind 0x%0h status 0x%0h data 0x%0h",
               kind_o, status_o, data_byte_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        field_check("kind",         32'(want.kind),         32'(kind_o));
        field_check("data_byte",    32'(want.data_byte),    32'(data_byte_o));
        field_check("status",       32'(want.status),       32'(status_o));
        field_check("dest_upper",   32'(want.dest_upper),   32'(dest_upper_o));
        field_check("dest_lower",   32'(want.dest_lower),   32'(dest_lower_o));
        field_check("src_upper",    32'(want.src_upper),    32'(src_upper_o));
        field_check("src_lower",    32'(want.src_lower),    32'(src_lower_o));
        field_check("control",      32'(want.control),      32'(control_o));
        field_check("frame_length", 32'(want.frame_length), 32'(frame_length_o));
      end
    end
  end

  // Receiver stalls in runs of random length, with calm stretches in between.
  initial begin
    int unsigned n;
    out_stall_i <= 1'b0;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
      n = idle_len(rx_calm);
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  initial begin
    bit          yields;
    bit          counts;
    res_t        want;
    int unsigned sent;
    int unsigned frames;
    sent          = 0;
    frames        = 0;
    in_valid_i    <= 1'b0;
    rx_byte_i     <= 8'h00;
    end_of_data_i <= 1'b0;
    rst_ni        <= 1'b0;
    clear_frame();

    // The directed part: end of data while hunting, while dropping and within the
    // format field, a wrong type, a segmented frame, a flag while dropping, a length
    // below four and one short frame with extreme byte values whose FCS is wrong.
    directed_rows = '{
      '{8'h00, 1'b1, 1'b1, 1'b1, status_only(ST_NO_FRAME, 11'd0)},
      '{8'h7E, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h05, 1'b0, 1'b1, 1'b1, status_only(ST_WRONG_TYPE, 11'd5)},
      '{8'h7E, 1'b0, 1'b1, 1'b0, NO_RESULT},
      '{8'hFF, 1'b1, 1'b1, 1'b0, NO_RESULT},
      '{8'h7E, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'hA8, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h10, 1'b0, 1'b1, 1'b1, status_only(ST_SEGMENTED, 11'd16)},
      '{8'h00, 1'b1, 1'b1, 1'b0, NO_RESULT},
      '{8'h7E, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'hA0, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h03, 1'b0, 1'b1, 1'b1, status_only(ST_INCOMPLETE, 11'd3)},
      '{8'h7E, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'hA0, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b1, 1'b1, 1'b1, status_only(ST_INCOMPLETE, 11'd0)},
      '{8'h7E, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'hA0, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h08, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h12, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h34, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h7E, 1'b0, 1'b0, 1'b0, NO_RESULT}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].b, directed_rows[i].e);
      // The model always steps so that its state follows the block; a typed
      // row overrides what it predicts.
      predict_byte(directed_rows[i].b, directed_rows[i].e, yields, want);
      if (directed_rows[i].typed) begin
        if (directed_rows[i].yields) pending_results.push_back(directed_rows[i].want);
      end else if (yields) begin
        pending_results.push_back(want);
      end
    end
    drain_results();

    // Random frames until enough items have reached the parser proper; items
    // swallowed while hunting or dropping are not counted.
    while (sent < RAND_ITEMS) begin
      build_frame();
      tx_calm = ($urandom_range(0, 5) == 0);
      foreach (link_q[i]) begin
        counts = !(rx_phase == PH_DROP ||
                   (rx_phase == PH_HUNT && !link_q[i].e && link_q[i].b != FLAG_BYTE));
        send_item(link_q[i].b, link_q[i].e);
        predict_byte(link_q[i].b, link_q[i].e, yields, want);
        if (yields) pending_results.push_back(want);
        if (counts) sent++;
      end
      frames++;
      if (frames % 40 == 39) drain_results();
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
